>>> hw/rtl/fmbq_pkg.sv
package fmbq_pkg;

  // Operation codes carried by a transaction.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_MIDDLE = 3'd1,
    OP_PUSH_BACK   = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_POP_MIDDLE  = 3'd4,
    OP_POP_BACK    = 3'd5
  } op_e;

  // Completion status reported with every result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int OP_WIDTH     = 3;
  localparam int STATUS_WIDTH = 2;

endpackage

>>> hw/rtl/front_middle_back_queue.sv
// An accepted transaction enters the execute state; its result is then registered, with
// done_o high for exactly one cycle; busy_o is high in between.
// Busy: no new transaction is accepted in the execute state, which does the read-then-write
// of the two synchronous ring memories (front half and back half, one port pair each).
// Reset: rst_ni clears the ring heads and counts, so the queue starts empty; ring
// contents are not cleared. The receiver cannot stall, so results are never held.
module front_middle_back_queue #(
  parameter int CAPACITY   = 1024,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [fmbq_pkg::OP_WIDTH-1:0]       op_i,
  input  logic signed [ITEM_WIDTH-1:0]        value_i,
  output logic                                done_o,
  output logic signed [ITEM_WIDTH-1:0]        popped_o,
  output logic [fmbq_pkg::STATUS_WIDTH-1:0]   status_o
);

  localparam int FD  = CAPACITY / 2;
  localparam int BD  = CAPACITY - CAPACITY / 2;
  localparam int FAW = (FD > 1) ? $clog2(FD) : 1;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int FCW = $clog2(FD + 1);
  localparam int BCW = $clog2(BD + 1);
  localparam int FSW = FCW + 1;
  localparam int BSW = BCW + 1;
  localparam int TW  = $clog2(CAPACITY + 1);

  localparam logic [FSW-1:0] FD_S   = FSW'(FD);
  localparam logic [BSW-1:0] BD_S   = BSW'(BD);
  localparam logic [FAW-1:0] F_TOP  = FAW'(FD - 1);
  localparam logic [BAW-1:0] B_TOP  = BAW'(BD - 1);
  localparam logic [TW-1:0]  CAP_T  = TW'(CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                  state_q, state_d;
  logic [FAW-1:0]          fh_q, fh_d;
  logic [FCW-1:0]          fc_q, fc_d;
  logic [BAW-1:0]          bh_q, bh_d;
  logic [BCW-1:0]          bc_q, bc_d;
  fmbq_pkg::op_e           op_q;
  logic [ITEM_WIDTH-1:0]   value_q;
  logic                    done_q;
  logic [ITEM_WIDTH-1:0]   popped_q, popped_d;
  fmbq_pkg::status_e       status_q, status_d;

  logic                    accept;
  logic [TW-1:0]           fc_t, bc_t, total;
  logic                    fc_eq, bgt, q_full, q_empty;

  logic [FSW-1:0]          f_tail_s, f_last_s;
  logic [BSW-1:0]          b_tail_s, b_last_s;
  logic [FAW-1:0]          f_tail, f_last, f_prev, f_next;
  logic [BAW-1:0]          b_tail, b_last, b_prev, b_next;

  logic                    f_we, b_we;
  logic [FAW-1:0]          f_waddr, f_raddr;
  logic [BAW-1:0]          b_waddr, b_raddr;
  logic [ITEM_WIDTH-1:0]   f_wdata, b_wdata, f_rdata, b_rdata;

  assign busy_o = (state_q == ST_EXEC);
  assign accept = start_i && !busy_o;

  // Occupancy and balance of the two halves.
  assign fc_t    = TW'(fc_q);
  assign bc_t    = TW'(bc_q);
  assign total   = fc_t + bc_t;
  assign fc_eq   = (fc_t == bc_t);
  assign bgt     = (bc_t > fc_t);
  assign q_full  = (total == CAP_T);
  assign q_empty = (total == '0);

  // Ring positions of the front half, wrapped by one conditional subtract.
  assign f_tail_s = FSW'(fh_q) + FSW'(fc_q);
  assign f_last_s = f_tail_s - FSW'(1);
  assign f_tail   = (f_tail_s >= FD_S) ? FAW'(f_tail_s - FD_S) : FAW'(f_tail_s);
  assign f_last   = (f_last_s >= FD_S) ? FAW'(f_last_s - FD_S) : FAW'(f_last_s);
  assign f_prev   = (fh_q == '0) ? F_TOP : FAW'(fh_q - FAW'(1));
  assign f_next   = (fh_q == F_TOP) ? '0 : FAW'(fh_q + FAW'(1));

  // Ring positions of the back half.
  assign b_tail_s = BSW'(bh_q) + BSW'(bc_q);
  assign b_last_s = b_tail_s - BSW'(1);
  assign b_tail   = (b_tail_s >= BD_S) ? BAW'(b_tail_s - BD_S) : BAW'(b_tail_s);
  assign b_last   = (b_last_s >= BD_S) ? BAW'(b_last_s - BD_S) : BAW'(b_last_s);
  assign b_prev   = (bh_q == '0) ? B_TOP : BAW'(bh_q - BAW'(1));
  assign b_next   = (bh_q == B_TOP) ? '0 : BAW'(bh_q + BAW'(1));

  // Read addresses are issued with the accepted transaction; both halves are read.
  assign f_raddr = (fmbq_pkg::op_e'(op_i) == fmbq_pkg::OP_POP_FRONT) ? fh_q : f_last;
  assign b_raddr = (fmbq_pkg::op_e'(op_i) == fmbq_pkg::OP_POP_BACK) ? b_last : bh_q;

  fmbq_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (FD)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (accept),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  fmbq_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (BD)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (accept),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Execute cycle: apply the operation and rebalance, writing at most one entry per half.
  always_comb begin
    fh_d     = fh_q;
    fc_d     = fc_q;
    bh_d     = bh_q;
    bc_d     = bc_q;
    f_we     = 1'b0;
    f_waddr  = f_tail;
    f_wdata  = value_q;
    b_we     = 1'b0;
    b_waddr  = b_tail;
    b_wdata  = value_q;
    popped_d = '1;
    status_d = fmbq_pkg::ST_OK;
    if (state_q == ST_EXEC) begin
      case (op_q)
        fmbq_pkg::OP_PUSH_FRONT: begin
          if (q_full) begin
            status_d = fmbq_pkg::ST_FULL;
          end else if (fc_eq) begin
            // The last front item crosses to the back half.
            if (fc_q != '0) begin
              f_we    = 1'b1;
              f_waddr = f_prev;
              fh_d    = f_prev;
              b_wdata = f_rdata;
            end
            b_we    = 1'b1;
            b_waddr = b_prev;
            bh_d    = b_prev;
            bc_d    = bc_q + BCW'(1);
          end else begin
            f_we    = 1'b1;
            f_waddr = f_prev;
            fh_d    = f_prev;
            fc_d    = fc_q + FCW'(1);
          end
        end
        fmbq_pkg::OP_PUSH_MIDDLE: begin
          if (q_full) begin
            status_d = fmbq_pkg::ST_FULL;
          end else if (fc_eq) begin
            b_we    = 1'b1;
            b_waddr = b_prev;
            bh_d    = b_prev;
            bc_d    = bc_q + BCW'(1);
          end else begin
            f_we    = 1'b1;
            f_waddr = f_tail;
            fc_d    = fc_q + FCW'(1);
          end
        end
        fmbq_pkg::OP_PUSH_BACK: begin
          if (q_full) begin
            status_d = fmbq_pkg::ST_FULL;
          end else begin
            b_we    = 1'b1;
            b_waddr = b_tail;
            if (bgt) begin
              // The first back item moves to the tail of the front half.
              f_we    = 1'b1;
              f_waddr = f_tail;
              f_wdata = b_rdata;
              fc_d    = fc_q + FCW'(1);
              bh_d    = b_next;
            end else begin
              bc_d    = bc_q + BCW'(1);
            end
          end
        end
        fmbq_pkg::OP_POP_FRONT: begin
          if (q_empty) begin
            status_d = fmbq_pkg::ST_EMPTY;
          end else if (fc_q != '0) begin
            popped_d = f_rdata;
            fh_d     = f_next;
            if (bgt) begin
              f_we    = 1'b1;
              f_waddr = f_tail;
              f_wdata = b_rdata;
              bh_d    = b_next;
              bc_d    = bc_q - BCW'(1);
            end else begin
              fc_d    = fc_q - FCW'(1);
            end
          end else begin
            popped_d = b_rdata;
            bh_d     = b_next;
            bc_d     = bc_q - BCW'(1);
          end
        end
        fmbq_pkg::OP_POP_MIDDLE: begin
          if (q_empty) begin
            status_d = fmbq_pkg::ST_EMPTY;
          end else if (bgt) begin
            popped_d = b_rdata;
            bh_d     = b_next;
            bc_d     = bc_q - BCW'(1);
          end else begin
            popped_d = f_rdata;
            fc_d     = fc_q - FCW'(1);
          end
        end
        fmbq_pkg::OP_POP_BACK: begin
          if (q_empty) begin
            status_d = fmbq_pkg::ST_EMPTY;
          end else begin
            popped_d = b_rdata;
            if (fc_eq) begin
              // The last front item becomes the first back item.
              b_we    = 1'b1;
              b_waddr = b_prev;
              b_wdata = f_rdata;
              bh_d    = b_prev;
              fc_d    = fc_q - FCW'(1);
            end else begin
              bc_d    = bc_q - BCW'(1);
            end
          end
        end
        default: begin
          status_d = fmbq_pkg::ST_OK;
        end
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    case (state_q)
      ST_IDLE: state_d = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer, ring pointers and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fh_q     <= '0;
      fc_q     <= '0;
      bh_q     <= '0;
      bc_q     <= '0;
      done_q   <= 1'b0;
      op_q     <= fmbq_pkg::OP_PUSH_FRONT;
      value_q  <= '0;
      popped_q <= '1;
      status_q <= fmbq_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      fh_q    <= fh_d;
      fc_q    <= fc_d;
      bh_q    <= bh_d;
      bc_q    <= bc_d;
      done_q  <= (state_q == ST_EXEC);
      if (accept) begin
        op_q    <= fmbq_pkg::op_e'(op_i);
        value_q <= value_i;
      end
      if (state_q == ST_EXEC) begin
        popped_q <= popped_d;
        status_q <= status_d;
      end
    end
  end

  assign done_o   = done_q;
  assign popped_o = popped_q;
  assign status_o = status_q;

  // The back half holds as many items as the front half, or one more.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bc_t == fc_t) || (bc_t == TW'(fc_t + TW'(1))))
    else $error("halves out of balance");

  // Every accepted transaction is followed by its result strobe once the execute state has passed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("result strobe missing after accepted transaction");

  // A result appears only after an execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without execute cycle");

  // A full status is reported only when the queue held its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_q == fmbq_pkg::ST_FULL)) |-> $past(q_full))
    else $error("full status while queue not full");

  // Failed transactions and pushes return all ones.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_q != fmbq_pkg::ST_OK)) |-> (popped_q == '1))
    else $error("failed transaction returned data");

endmodule

>>> hw/rtl/fmbq_ram.sv
module fmbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
